@@ design/pfb_pkg.sv @@
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared sizes, request codes, command bytes and the stream descriptor for
// the paged frame buffer refresh block.
// ----------------------------------------------------------------------------
`default_nettype none

package pfb_pkg;

	// frame geometry
	localparam int COLUMNS = 128;
	localparam int PAGES   = 8;
	localparam int DEPTH   = COLUMNS * PAGES;
	localparam int HEADER_BYTES = 3;

	localparam int MEM_W  = $clog2(DEPTH);
	localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int POS_W  = $clog2(COLUMNS + HEADER_BYTES);

	// request codes
	typedef enum logic [1:0] {
		REQ_DRAW  = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_FETCH = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// command bytes of the page header
	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_LOW   = 8'h00;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

	// current position of the refresh stream
	typedef struct packed {
		logic [7:0]       cmd_byte;
		logic             is_data;
		logic             last;
		logic [MEM_W-1:0] addr;
	} stream_t;

endpackage

`default_nettype wire

@@ design/pfb_stream.sv @@
// ----------------------------------------------------------------------------
// pfb_stream
// Refresh stream sequencer: page and position counters, the header command
// bytes and the frame memory address of the next data byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_stream (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              advance,
	output pfb_pkg::stream_t cur
);
	import pfb_pkg::*;

	logic [PAGE_W-1:0] page_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  pos_col;
	logic [COL_W-1:0]  col;
	logic              pos_wrap;
	logic              page_wrap;

	assign pos_col   = pos_q - POS_W'(HEADER_BYTES);
	assign col       = pos_col[COL_W-1:0];
	assign pos_wrap  = (pos_q == POS_W'(COLUMNS + HEADER_BYTES - 1));
	assign page_wrap = (page_q == PAGE_W'(PAGES - 1));

	// header commands, then data bytes of the page
	always_comb begin
		cur.is_data = 1'b0;
		cur.last    = 1'b0;
		cur.addr    = MEM_W'(col) * MEM_W'(PAGES) + MEM_W'(page_q);
		priority if (pos_q == POS_W'(0)) begin
			cur.cmd_byte = CMD_PAGE_BASE + 8'(page_q);
		end else if (pos_q == POS_W'(1)) begin
			cur.cmd_byte = CMD_COL_LOW;
		end else if (pos_q == POS_W'(2)) begin
			cur.cmd_byte = CMD_COL_HIGH;
		end else begin
			cur.cmd_byte = CMD_COL_LOW;
			cur.is_data  = 1'b1;
			cur.last     = pos_wrap && page_wrap;
		end
	end

	// step the counters once per fetched item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= '0;
			pos_q  <= '0;
		end else if (advance) begin
			if (pos_wrap) begin
				pos_q  <= '0;
				page_q <= page_wrap ? '0 : page_q + PAGE_W'(1);
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ design/paged_frame_buffer_refresh.sv @@
// ----------------------------------------------------------------------------
// paged_frame_buffer_refresh
// Monochrome paged frame buffer with pixel draw, buffer clear and a refresh
// byte stream of page commands and column data.
// ----------------------------------------------------------------------------
// Usage:
// - input channel (in_valid/in_ready) carries a request: draw a pixel, clear
//   the buffer, or fetch the next refresh byte. only a fetch gives a result.
// - output channel (out_valid/out_ready) carries out_byte, is_data and
//   frame_last, one item per fetch, in request order.
// - draw: frame memory read, then modify and write back.
// - fetch: frame memory read, then load into the output register; the load
//   waits while the output register still holds an item not yet taken.
// - clear: sweeps all COLUMNS*PAGES (1024) bytes of the frame memory to zero,
//   one byte per cycle; in_ready stays low meanwhile.
// - the frame memory serves one request at a time: a fetch makes one read,
//   a draw one read-modify-write.
// - reset: counters go to page 0, first header byte; the same sweep zeroes
//   the frame memory before the first request is taken.
// - a stalled receiver holds the output register; a further fetch then waits
//   after its memory read until the register frees up, while the pending item
//   stays on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_frame_buffer_refresh (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [1:0] req_type,
	input  wire  [7:0] x_coord,
	input  wire  [7:0] y_coord,
	input  wire        fill,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] out_byte,
	output logic       is_data,
	output logic       frame_last
);
	import pfb_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_DRAW  = 4'b0100,
		ST_FETCH = 4'b1000
	} state_t;

	state_t state_q;
	logic [MEM_W-1:0] clr_q;

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;

	logic             accept;
	req_t             req;
	logic             draw_ok;
	logic [PAGE_W-1:0] draw_page;
	logic [MEM_W-1:0] draw_addr;
	logic [MEM_W-1:0] rd_addr;
	logic             we;
	logic [MEM_W-1:0] wr_addr;
	logic [7:0]       wr_data;
	logic             load_out;
	stream_t          strm;

	logic [MEM_W-1:0] draw_addr_s1;
	logic [7:0]       mask_s1;
	logic             fill_s1;
	logic [7:0]       cmd_s1;
	logic             is_data_s1;
	logic             last_s1;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       is_data_q;
	logic       last_q;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign req      = req_t'(req_type);

	// draw address: flipped page, column-major layout
	assign draw_ok   = ({1'b0, x_coord} < 9'(COLUMNS)) && ({1'b0, y_coord} < 9'(8 * PAGES));
	assign draw_page = PAGE_W'(PAGES - 1) - PAGE_W'(y_coord[7:3]);
	assign draw_addr = MEM_W'(x_coord) * MEM_W'(PAGES) + MEM_W'(draw_page);
	assign rd_addr   = (req == REQ_FETCH) ? strm.addr : draw_addr;

	pfb_stream u_stream (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept && (req == REQ_FETCH)),
		.cur     (strm)
	);

	// memory write port: sweep zeros or write back a modified byte
	always_comb begin
		we      = 1'b0;
		wr_addr = draw_addr_s1;
		wr_data = fill_s1 ? (rd_q | mask_s1) : (rd_q & ~mask_s1);
		if (state_q == ST_CLEAR) begin
			we      = 1'b1;
			wr_addr = clr_q;
			wr_data = 8'h00;
		end else if (state_q == ST_DRAW) begin
			we = 1'b1;
		end
	end

	// frame memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (accept) begin
			rd_q <= mem[rd_addr];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			draw_addr_s1 <= draw_addr;
			mask_s1      <= 8'h80 >> y_coord[2:0];
			fill_s1      <= fill;
			cmd_s1       <= strm.cmd_byte;
			is_data_s1   <= strm.is_data;
			last_s1      <= strm.last;
		end
	end

	assign load_out = (state_q == ST_FETCH) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + MEM_W'(1);
					if (clr_q == MEM_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (req)
							REQ_DRAW: begin
								if (draw_ok) begin
									state_q <= ST_DRAW;
								end
							end
							REQ_CLEAR: begin
								state_q <= ST_CLEAR;
								clr_q   <= '0;
							end
							REQ_FETCH: state_q <= ST_FETCH;
							REQ_NONE:  state_q <= ST_IDLE;
							default:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DRAW: state_q <= ST_IDLE;
				ST_FETCH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_byte_q <= is_data_s1 ? rd_q : cmd_s1;
			is_data_q  <= is_data_s1;
			last_q     <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign is_data    = is_data_q;
	assign frame_last = last_q;

endmodule

`default_nettype wire

@@ design/pfb_checker.sv @@
// ----------------------------------------------------------------------------
// pfb_checker
// Port-level checks for the paged frame buffer refresh block, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire [1:0] req_type,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] out_byte,
	input wire       is_data,
	input wire       frame_last
);
	import pfb_pkg::*;

	// a stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_data)
			&& $stable(frame_last))
	else $error("stalled result changed");

	// the frame end mark only comes on a data byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> is_data)
	else $error("frame_last on a command byte");

	// command bytes are a page command or a column command
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_data |->
			out_byte == CMD_COL_LOW || out_byte == CMD_COL_HIGH
			|| out_byte[7:4] == CMD_PAGE_BASE[7:4])
	else $error("unexpected command byte");

	// a clear blocks input while the buffer is swept
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == REQ_CLEAR |=> !in_ready)
	else $error("input taken during clear sweep");

	// a fetch holds off the next item for its memory read
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == REQ_FETCH |=> !in_ready)
	else $error("input taken during fetch");

endmodule

bind paged_frame_buffer_refresh pfb_checker u_pfb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.req_type   (req_type),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.is_data    (is_data),
	.frame_last (frame_last)
);

`default_nettype wire

@@ verif/tb_paged_frame_buffer_refresh.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_paged_frame_buffer_refresh
// Self-checking bench for the paged frame buffer refresh block. A directed
// table covers reset state, coordinate extremes, ignored draws, the unused
// request code and clears. A mixed random phase follows. A shadow frame
// buffer predicts every refresh byte. Both sides idle at random, and the
// receiver holds off once long enough to back up the block.
// ----------------------------------------------------------------------------
module tb_paged_frame_buffer_refresh;
	import pfb_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int MIXED_ITEMS  = 480;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [7:0] value;
		logic       is_data;
		logic       last;
	} stream_byte_t;

	typedef struct {
		req_t         req;
		logic [7:0]   x;
		logic [7:0]   y;
		logic         fill;
		bit           typed;
		stream_byte_t want;
	} table_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] req_type;
	logic [7:0] x_coord;
	logic [7:0] y_coord;
	logic       fill;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       frame_last;

	// shadow copy of the block state
	logic [7:0]   shadow_frame [COLUMNS*PAGES];
	int           shadow_page;
	int           shadow_pos;
	stream_byte_t pending_bytes [$];
	table_row_t   directed [$];

	int  cycle_count;
	int  mismatches;
	int  results_seen;
	bit  calm;
	bit  hold_done;

	paged_frame_buffer_refresh u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.fill       (fill),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.is_data    (is_data),
		.frame_last (frame_last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// idle length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// apply one accepted request to the shadow state
	task automatic track_request(input req_t req, input logic [7:0] x, input logic [7:0] y,
			input logic f, input bit typed, input stream_byte_t want);
		int xi;
		int yi;
		int idx;
		int col;
		stream_byte_t sb;
		xi = x;
		yi = y;
		case (req)
			REQ_DRAW: begin
				if (xi < COLUMNS && yi < PAGES * 8) begin
					idx = xi * PAGES + (PAGES - 1 - yi / 8);
					shadow_frame[idx][7 - yi % 8] = f;
				end
			end
			REQ_CLEAR: begin
				foreach (shadow_frame[i])
					shadow_frame[i] = 8'h00;
			end
			REQ_FETCH: begin
				sb.is_data = 1'b0;
				sb.last    = 1'b0;
				if (shadow_pos == 0) begin
					sb.value = CMD_PAGE_BASE + 8'(shadow_page);
				end else if (shadow_pos == 1) begin
					sb.value = CMD_COL_LOW;
				end else if (shadow_pos == 2) begin
					sb.value = CMD_COL_HIGH;
				end else begin
					col = shadow_pos - HEADER_BYTES;
					sb.value   = shadow_frame[col * PAGES + shadow_page];
					sb.is_data = 1'b1;
					sb.last    = (col == COLUMNS - 1) && (shadow_page == PAGES - 1);
				end
				shadow_pos++;
				if (shadow_pos >= COLUMNS + HEADER_BYTES) begin
					shadow_pos = 0;
					shadow_page = (shadow_page + 1) % PAGES;
				end
				pending_bytes.push_back(typed ? want : sb);
			end
			default: ;
		endcase
	endtask

	// offer one item and wait for it to be taken
	task automatic send_request(input req_t req, input logic [7:0] x, input logic [7:0] y,
			input logic f, input bit typed, input stream_byte_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		req_type = req;
		x_coord  = x;
		y_coord  = y;
		fill     = f;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_request(req, x, y, f, typed, want);
		@(negedge clk);
	endtask

	// random request with the given mix, in percent; the rest is the unused code
	task automatic send_random(input int draw_pct, input int fetch_pct, input int clear_pct);
		int r;
		req_t req;
		logic [7:0] x;
		logic [7:0] y;
		stream_byte_t none;
		none = '{8'h00, 1'b0, 1'b0};
		r = $urandom_range(0, 99);
		if (r < draw_pct)
			req = REQ_DRAW;
		else if (r < draw_pct + fetch_pct)
			req = REQ_FETCH;
		else if (r < draw_pct + fetch_pct + clear_pct)
			req = REQ_CLEAR;
		else
			req = REQ_NONE;
		// mostly on-screen pixels, some off the edges
		x = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 127)) :
			8'($urandom_range(128, 255));
		y = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 63)) :
			8'($urandom_range(64, 255));
		send_request(req, x, y, 1'($urandom_range(0, 1)), 1'b0, none);
	endtask

	function automatic void add_row(input req_t req, input int x, input int y, input bit f,
			input bit typed, input int wb, input bit wd, input bit wl);
		table_row_t row;
		row.req  = req;
		row.x    = 8'(x);
		row.y    = 8'(y);
		row.fill = f;
		row.typed = typed;
		row.want = '{8'(wb), wd, wl};
		directed.push_back(row);
	endfunction

	// receiver ready: random stalls plus one long hold-off
	initial begin
		int stall_left;
		stall_left = 0;
		hold_done  = 1'b0;
		out_ready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 40) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// compare each taken refresh byte with the oldest prediction
	always @(posedge clk) begin
		stream_byte_t exp_b;
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (pending_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: byte %02h data %0b last %0b",
						out_byte, is_data, frame_last);
			end else begin
				exp_b = pending_bytes.pop_front();
				if (out_byte !== exp_b.value || is_data !== exp_b.is_data ||
						frame_last !== exp_b.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: got byte %02h data %0b last %0b, ",
							"expected byte %02h data %0b last %0b"},
							out_byte, is_data, frame_last,
							exp_b.value, exp_b.is_data, exp_b.last);
				end
			end
		end
	end

	// stimulus
	initial begin
		int i;
		cycle_count  = 0;
		mismatches   = 0;
		results_seen = 0;
		calm         = 1'b0;
		shadow_page  = 0;
		shadow_pos   = 0;
		foreach (shadow_frame[k])
			shadow_frame[k] = 8'h00;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_NONE;
		x_coord  = 8'h00;
		y_coord  = 8'h00;
		fill     = 1'b0;

		// stream start after reset, then edges of the screen
		add_row(REQ_FETCH, 0, 0, 0, 1, 8'hB0, 0, 0);
		add_row(REQ_FETCH, 0, 0, 0, 1, 8'h00, 0, 0);
		add_row(REQ_FETCH, 0, 0, 0, 1, 8'h10, 0, 0);
		add_row(REQ_FETCH, 0, 0, 0, 1, 8'h00, 1, 0);
		add_row(REQ_DRAW, 0, 0, 1, 0, 0, 0, 0);
		add_row(REQ_DRAW, 127, 63, 1, 0, 0, 0, 0);
		add_row(REQ_DRAW, 1, 56, 1, 0, 0, 0, 0);
		add_row(REQ_FETCH, 0, 0, 0, 0, 0, 0, 0);
		// off-screen draws and the unused code change nothing
		add_row(REQ_DRAW, 128, 0, 1, 0, 0, 0, 0);
		add_row(REQ_DRAW, 0, 64, 1, 0, 0, 0, 0);
		add_row(REQ_DRAW, 255, 255, 1, 0, 0, 0, 0);
		add_row(REQ_NONE, 2, 63, 1, 0, 0, 0, 0);
		add_row(REQ_DRAW, 1, 56, 0, 0, 0, 0, 0);
		add_row(REQ_DRAW, 2, 56, 1, 0, 0, 0, 0);
		add_row(REQ_DRAW, 2, 63, 1, 0, 0, 0, 0);
		add_row(REQ_FETCH, 0, 0, 0, 0, 0, 0, 0);
		add_row(REQ_DRAW, 3, 7, 1, 0, 0, 0, 0);
		add_row(REQ_DRAW, 3, 8, 1, 0, 0, 0, 0);
		// clear keeps the stream position but empties the buffer
		add_row(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		add_row(REQ_FETCH, 0, 0, 0, 1, 8'h00, 1, 0);
		add_row(REQ_DRAW, 4, 0, 1, 0, 0, 0, 0);
		add_row(REQ_DRAW, 4, 63, 1, 0, 0, 0, 0);
		add_row(REQ_FETCH, 0, 0, 0, 0, 0, 0, 0);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[r])
			send_request(directed[r].req, directed[r].x, directed[r].y, directed[r].fill,
				directed[r].typed, directed[r].want);

		// mixed traffic, with a stretch of no idling
		for (i = 0; i < MIXED_ITEMS; i++) begin
			calm = (i >= 150 && i < 250);
			send_random(45, 47, 3);
		end
		calm = 1'b0;

		in_valid = 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
design/pfb_pkg.sv
design/pfb_stream.sv
design/paged_frame_buffer_refresh.sv
design/pfb_checker.sv
verif/tb_paged_frame_buffer_refresh.sv
